// File: sv/phi_negacyclic_poly_mul_mod_q_assert.svh
// Assertion helpers for the phi negacyclic multiplier.
`ifndef PHI_NEGACYCLIC_POLY_MUL_MOD_Q_ASSERT_SVH
`define PHI_NEGACYCLIC_POLY_MUL_MOD_Q_ASSERT_SVH

// Same-cycle implication, checked on aclk while aresetn is high.
`define PNPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk while aresetn is high.
`define PNPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pnpm_pkg.sv
`timescale 1ns / 1ps

package pnpm_pkg;

    localparam int DEGREE = 8;

    localparam int IN_W   = 13;
    localparam int COEF_W = 12;
    localparam int MUL_W  = 2 * COEF_W;

    localparam int S_TDATA_W = ((4 * IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * COEF_W + 7) / 8) * 8;

    localparam longint unsigned MODQ_L   = 64'd3329;
    localparam longint unsigned DEGREE_L = 64'(DEGREE);

    localparam logic [COEF_W-1:0] MODQ   = COEF_W'(MODQ_L);
    localparam logic signed [IN_W:0] MODQ_S = (IN_W + 1)'(MODQ_L);

    // Counter covers loads, compute steps and the extra drain step.
    localparam int CNT_W = (DEGREE < 2) ? 1 : $clog2(DEGREE + 1);

    // An accumulator takes up to three reduced products per step for DEGREE steps.
    localparam longint unsigned ACC_MAX = 64'd3 * (MODQ_L - 64'd1) * (MODQ_L - 64'd1) * DEGREE_L;
    localparam int ACC_W = $clog2(ACC_MAX + 64'd1);

    // Barrett constants for the final reduction of an accumulator.
    localparam int BAR_S = ACC_W + COEF_W;
    localparam longint unsigned BAR_M_L = (64'd1 << BAR_S) / MODQ_L;
    localparam int M_W    = $clog2(BAR_M_L + 64'd1);
    localparam int PROD_W = ACC_W + M_W;
    localparam int QT_W   = PROD_W - BAR_S;
    localparam int T_W    = QT_W + COEF_W;
    localparam logic [M_W-1:0] BAR_M = M_W'(BAR_M_L);

    typedef logic [COEF_W-1:0] coef_t;
    typedef logic [ACC_W-1:0]  acc_t;
    typedef logic [MUL_W-1:0]  prod_t;

    typedef struct packed {
        coef_t phi;
        coef_t plain;
    } coef_pair_t;

    typedef struct packed {
        acc_t phi;
        acc_t plain;
    } acc_pair_t;

    typedef struct packed {
        logic y_load;
        logic y_rot;
        logic acc_clr;
        logic acc_add;
        logic acc_shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic  valid;
        logic  last;
        coef_t plain;
        coef_t phi;
    } red_res_t;

    // Maps any 13-bit two's-complement value into 0..q-1.
    function automatic coef_t red_in(input logic [IN_W-1:0] v);
        logic signed [IN_W:0] w;
        logic signed [IN_W:0] r;
        begin
            w = signed'({v[IN_W-1], v});
            if (w < -MODQ_S) begin
                r = w + MODQ_S + MODQ_S;
            end else if (w < 0) begin
                r = w + MODQ_S;
            end else if (w >= MODQ_S) begin
                r = w - MODQ_S;
            end else begin
                r = w;
            end
            red_in = COEF_W'(r);
        end
    endfunction

    // Negation mod q of a reduced coefficient.
    function automatic coef_t mod_neg(input coef_t v);
        begin
            mod_neg = (v == '0) ? '0 : coef_t'(MODQ - v);
        end
    endfunction

endpackage

// File: sv/pnpm_cell.sv
`timescale 1ns / 1ps

module pnpm_cell (
    input  logic                   aclk,
    input  pnpm_pkg::cell_ctrl_t   ctrl,
    input  pnpm_pkg::coef_pair_t   x_bc,
    input  pnpm_pkg::coef_pair_t   y_from_up,
    input  pnpm_pkg::coef_pair_t   y_from_down,
    input  pnpm_pkg::acc_pair_t    acc_from_up,
    output pnpm_pkg::coef_pair_t   y_out,
    output pnpm_pkg::acc_pair_t    acc_out
);
    import pnpm_pkg::*;

    coef_pair_t y_reg, y_next;
    prod_t      pp_reg, ff_reg, pf_reg, fp_reg;
    prod_t      pp_next, ff_next, pf_next, fp_next;
    acc_pair_t  acc_reg, acc_next;

    always_comb begin
        if (ctrl.y_load) begin
            y_next = y_from_up;
        end else if (ctrl.y_rot) begin
            y_next = y_from_down;
        end else begin
            y_next = y_reg;
        end
    end

    assign pp_next = MUL_W'(x_bc.plain) * MUL_W'(y_reg.plain);
    assign ff_next = MUL_W'(x_bc.phi)   * MUL_W'(y_reg.phi);
    assign pf_next = MUL_W'(x_bc.plain) * MUL_W'(y_reg.phi);
    assign fp_next = MUL_W'(x_bc.phi)   * MUL_W'(y_reg.plain);

    // The plain part gets xp*yp + xf*yf, the phi part xp*yf + xf*yp + xf*yf.
    always_comb begin
        if (ctrl.acc_clr) begin
            acc_next = '0;
        end else if (ctrl.acc_shift) begin
            acc_next = acc_from_up;
        end else if (ctrl.acc_add) begin
            acc_next.plain = acc_reg.plain + ACC_W'(pp_reg) + ACC_W'(ff_reg);
            acc_next.phi   = acc_reg.phi + ACC_W'(pf_reg) + ACC_W'(fp_reg) + ACC_W'(ff_reg);
        end else begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        y_reg   <= y_next;
        pp_reg  <= pp_next;
        ff_reg  <= ff_next;
        pf_reg  <= pf_next;
        fp_reg  <= fp_next;
        acc_reg <= acc_next;
    end

    assign y_out   = y_reg;
    assign acc_out = acc_reg;

endmodule

// File: sv/pnpm_reduce.sv
`timescale 1ns / 1ps

module pnpm_reduce (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  in_last,
    input  pnpm_pkg::acc_pair_t   in_acc,
    output pnpm_pkg::red_res_t    res
);
    import pnpm_pkg::*;

    acc_t              a_in [2];
    acc_t              a1_reg [2];
    acc_t              a2_reg [2];
    logic [PROD_W-1:0] prod_reg [2];
    acc_t              t_reg [2];
    logic [T_W-1:0]    t_full [2];
    acc_t              r_diff [2];
    coef_t             r_fin [2];

    logic v1_reg, v2_reg, l1_reg, l2_reg;

    assign a_in[0] = in_acc.plain;
    assign a_in[1] = in_acc.phi;

    // Quotient estimate is at most one low, so one conditional subtract finishes.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            t_full[l] = T_W'(prod_reg[l][PROD_W-1:BAR_S]) * T_W'(MODQ);
            r_diff[l] = a2_reg[l] - t_reg[l];
            if (r_diff[l] >= ACC_W'(MODQ)) begin
                r_fin[l] = COEF_W'(r_diff[l] - ACC_W'(MODQ));
            end else begin
                r_fin[l] = COEF_W'(r_diff[l]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int l = 0; l < 2; l++) begin
            a1_reg[l]   <= a_in[l];
            prod_reg[l] <= PROD_W'(a_in[l]) * PROD_W'(BAR_M);
            a2_reg[l]   <= a1_reg[l];
            t_reg[l]    <= t_full[l][ACC_W-1:0];
        end
        l1_reg <= in_last;
        l2_reg <= l1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign res.valid = v2_reg;
    assign res.last  = l2_reg;
    assign res.plain = r_fin[0];
    assign res.phi   = r_fin[1];

endmodule

// File: sv/phi_negacyclic_poly_mul_mod_q.sv
`timescale 1ns / 1ps
// Multiplies x = xp + xf*phi by y = yp + yf*phi (phi^2 = phi + 1), each part a
// polynomial mod (x^DEGREE + 1) over Z_3329.
// Input channel (s_): DEGREE beats, beat i carrying coefficient i of all four
// operand polynomials as signed 13-bit values. s_tready is high only while loading.
// Output channel (m_): DEGREE beats, beat k carrying coefficient k of r_plain and
// r_phi in 0..3328; m_tlast marks coefficient DEGREE-1.
// Operation: loading takes DEGREE beats. The y coefficients then rotate through a
// row of DEGREE cells while x is broadcast one coefficient a cycle; each cell
// accumulates one output coefficient. The accumulators then shift out through one
// Barrett reducer, which holds one coefficient at a time, so the next coefficient
// enters only after the previous result has left the reducer.
// Loading of the next block starts as soon as the last coefficient enters the
// reducer. When the receiver stalls, the beat waits in the output register and
// the next coefficient is held in the cell row. Reset (aresetn low, synchronous)
// empties the output register and the reducer and returns to loading.
`include "phi_negacyclic_poly_mul_mod_q_assert.svh"

module phi_negacyclic_poly_mul_mod_q (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // x_plain [12:0], x_phi [25:13], y_plain [38:26], y_phi [51:39], zero fill above
    input  logic [pnpm_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // r_plain [11:0], r_phi [23:12]
    output logic [pnpm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);
    import pnpm_pkg::*;

    localparam logic [1:0] ST_LOAD    = 2'd0;
    localparam logic [1:0] ST_COMPUTE = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic             m_tvalid_reg, m_tlast_reg;
    coef_t            r_plain_reg, r_phi_reg;

    logic s_beat, last_cnt, issue, rot, x_shift;

    coef_pair_t x_new, y_new;
    coef_pair_t x_line_reg [DEGREE];
    coef_pair_t y_out [DEGREE];
    coef_pair_t y_up [DEGREE];
    coef_pair_t y_dn [DEGREE];
    acc_pair_t  acc_out [DEGREE];
    acc_pair_t  acc_up [DEGREE];
    cell_ctrl_t ctrl;
    red_res_t   red_res;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_beat   = s_tvalid && s_tready;
    assign last_cnt = (cnt_reg == CNT_W'(DEGREE - 1));
    assign rot      = (state_reg == ST_COMPUTE) && (cnt_reg != CNT_W'(DEGREE));
    assign x_shift  = s_beat || rot;
    assign issue    = (state_reg == ST_EMIT) && !pend_reg && (!m_tvalid_reg || m_tready);

    assign x_new.plain = red_in(s_tdata[IN_W-1:0]);
    assign x_new.phi   = red_in(s_tdata[2*IN_W-1:IN_W]);
    assign y_new.plain = red_in(s_tdata[3*IN_W-1:2*IN_W]);
    assign y_new.phi   = red_in(s_tdata[4*IN_W-1:3*IN_W]);

    assign ctrl.y_load    = s_beat;
    assign ctrl.y_rot     = rot;
    assign ctrl.acc_clr   = (state_reg == ST_LOAD);
    assign ctrl.acc_add   = (state_reg == ST_COMPUTE) && (cnt_reg != '0);
    assign ctrl.acc_shift = issue;

    // x enters at the top and moves toward index 0, which feeds every cell.
    always_ff @(posedge aclk) begin
        if (x_shift) begin
            for (int k = 0; k < DEGREE - 1; k++) begin
                x_line_reg[k] <= x_line_reg[k + 1];
            end
            x_line_reg[DEGREE-1] <= x_new;
        end
    end

    // Loading moves y toward cell 0; computing rotates it upward, negating at the wrap.
    for (genvar k = 0; k < DEGREE; k++) begin : g_cell
        if (k == DEGREE - 1) begin : g_top
            assign y_up[k]   = y_new;
            assign acc_up[k] = '0;
        end else begin : g_mid
            assign y_up[k]   = y_out[k + 1];
            assign acc_up[k] = acc_out[k + 1];
        end
        if (k == 0) begin : g_wrap
            assign y_dn[k].plain = mod_neg(y_out[DEGREE-1].plain);
            assign y_dn[k].phi   = mod_neg(y_out[DEGREE-1].phi);
        end else begin : g_link
            assign y_dn[k] = y_out[k - 1];
        end

        pnpm_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .x_bc        (x_line_reg[0]),
            .y_from_up   (y_up[k]),
            .y_from_down (y_dn[k]),
            .acc_from_up (acc_up[k]),
            .y_out       (y_out[k]),
            .acc_out     (acc_out[k])
        );
    end

    pnpm_reduce u_reduce (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (issue),
        .in_last  (last_cnt),
        .in_acc   (acc_out[0]),
        .res      (red_res)
    );

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_beat) begin
                    if (last_cnt) begin
                        state_next = ST_COMPUTE;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_COMPUTE: begin
                if (cnt_reg == CNT_W'(DEGREE)) begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (issue) begin
                    if (last_cnt) begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
                cnt_next   = '0;
            end
        endcase
    end

    // Only one coefficient is in the reducer at a time.
    always_comb begin
        if (issue) begin
            pend_next = 1'b1;
        end else if (red_res.valid) begin
            pend_next = 1'b0;
        end else begin
            pend_next = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            if (red_res.valid) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (red_res.valid) begin
            r_plain_reg <= red_res.plain;
            r_phi_reg   <= red_res.phi;
            m_tlast_reg <= red_res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = M_TDATA_W'({r_phi_reg, r_plain_reg});

    `PNPM_ASSERT_IMP(a_out_reg_free, red_res.valid, !m_tvalid_reg, "reduced beat would overwrite a pending output beat")
    `PNPM_ASSERT_NEXT(a_compute_start, s_beat && last_cnt, state_reg == ST_COMPUTE, "compute did not start after the final load beat")
    `PNPM_ASSERT_IMP(a_compute_bound, state_reg == ST_COMPUTE, cnt_reg <= CNT_W'(DEGREE), "compute step count ran past the drain step")

endmodule
